[design/rei_pkg.sv]
// ----------------------------------------------------------------------------
// rei_pkg
// Shared constants and helpers for the ray/ellipsoid intersection pipeline.
// ----------------------------------------------------------------------------
package rei_pkg;

  // restoring divider: 64-bit dividend, 32-bit divisor, one quotient bit a stage
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DVS_W     = 32;
  localparam int unsigned DIV_STEPS = DIV_W;

  // integer square root: 64-bit radicand, one root bit a stage
  localparam int unsigned SQRT_W     = 64;
  localparam int unsigned ROOT_W     = SQRT_W / 2;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEMI_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEMI_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEMI_Z   = 3'd5;

  // drop 16 fraction bits, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] m;
    mag = x[63] ? 64'(-x) : 64'(x);
    m   = (mag + 64'd32768) >> 16;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

[design/rei_div.sv]
// ----------------------------------------------------------------------------
// rei_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rei_div (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [rei_pkg::DIV_W-1:0] dvd_i,
  input  logic [rei_pkg::DVS_W-1:0] dvs_i,
  output logic [rei_pkg::DIV_W-1:0] quo_o
);
  import rei_pkg::*;

  // dividend bits shift out at the top while quotient bits shift in below
  logic [DIV_W-1:0] x_q   [DIV_STEPS];
  logic [DVS_W-1:0] rem_q [DIV_STEPS];
  logic [DVS_W-1:0] dvs_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DIV_W-1:0] x_in;
    logic [DVS_W-1:0] r_in;
    logic [DVS_W-1:0] v_in;
    logic [DVS_W:0]   t;
    logic             ge;

    if (k == 0) begin : g_first
      assign x_in = dvd_i;
      assign r_in = '0;
      assign v_in = dvs_i;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = rem_q[k-1];
      assign v_in = dvs_q[k-1];
    end

    assign t  = {r_in, x_in[DIV_W-1]};
    assign ge = t >= {1'b0, v_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]   <= {x_in[DIV_W-2:0], ge};
        rem_q[k] <= ge ? DVS_W'(t - {1'b0, v_in}) : t[DVS_W-1:0];
        dvs_q[k] <= v_in;
      end
    end
  end

  assign quo_o = x_q[DIV_STEPS-1];

endmodule

[design/rei_sqrt.sv]
// ----------------------------------------------------------------------------
// rei_sqrt
// Pipelined integer square root (floor), one root bit per register stage.
// ----------------------------------------------------------------------------
module rei_sqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [rei_pkg::SQRT_W-1:0] rad_i,
  output logic [rei_pkg::ROOT_W-1:0] root_o
);
  import rei_pkg::*;

  logic [SQRT_W-1:0] x_q [SQRT_STEPS];
  logic [SQRT_W-1:0] r_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQRT_W-1:0] Bit = SQRT_W'(1) << (SQRT_W - 2 - 2 * k);
    logic [SQRT_W-1:0] x_in;
    logic [SQRT_W-1:0] r_in;
    logic [SQRT_W-1:0] trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign x_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign trial = r_in + Bit;
    assign ge    = x_in >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k] <= ge ? x_in - trial : x_in;
        r_q[k] <= ge ? (r_in >> 1) + Bit : r_in >> 1;
      end
    end
  end

  assign root_o = r_q[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

[design/ray_ellipsoid_intersect_top.sv]
// ----------------------------------------------------------------------------
// ray_ellipsoid_intersect_top
// Ray against axis-aligned ellipsoid, signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  ray     | in        | in_valid_i/in_stall_o   | ray_origin_*_i, ray_dir_*_i
//  result  | out       | out_valid_o/out_stall_i | hit_o, hit_x/y/z_o
//
//  One ray enters per cycle while in_stall_o is low; 214 register stages, most of
//  them in two 64-stage dividers and two 32-stage roots.
//  Reset clears configuration to center 0, semi-axes 1.0, and all valid bits.
//  A stalled result freezes the whole pipeline; in_stall_o follows at once.
//  Configuration is always ready and is read live, not carried along with each ray.
// ----------------------------------------------------------------------------
module ray_ellipsoid_intersect_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rei_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                         cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [31:0]                  ray_origin_x_i,
  input  logic signed [31:0]                  ray_origin_y_i,
  input  logic signed [31:0]                  ray_origin_z_i,
  input  logic signed [31:0]                  ray_dir_x_i,
  input  logic signed [31:0]                  ray_dir_y_i,
  input  logic signed [31:0]                  ray_dir_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic signed [31:0]                  hit_x_o,
  output logic signed [31:0]                  hit_y_o,
  output logic signed [31:0]                  hit_z_o
);
  import rei_pkg::*;

  // --------------------------------------------------------------------------
  // stage types
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0]       neg_o;
    logic [2:0]       neg_d;
    logic [2:0][32:0] omag;
    logic [2:0][31:0] dmag;
  } s0_t;

  typedef struct packed {
    logic       valid;
    logic       bad;
    logic [2:0] neg_o;
    logic [2:0] neg_d;
  } sb1_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0]       neg_d;
    logic [2:0][31:0] u;
    logic [2:0][63:0] e;
    logic [63:0]      orv;
  } s1_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0]       neg_d;
    logic [2:0][31:0] u;
    logic [2:0][63:0] e;
    logic [3:0]       nz;
    logic [3:0][3:0]  pos;
  } s2_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0]       neg_d;
    logic [2:0][31:0] u;
    logic [2:0][63:0] e;
    logic [5:0]       lead;
  } s3_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0]       neg_d;
    logic [2:0][31:0] u;
    logic [2:0][29:0] em;
  } s4_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0]       neg_d;
    logic [2:0][31:0] u;
    logic [2:0][29:0] em;
    logic [2:0][59:0] sq;
  } s5_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0]       neg_d;
    logic [2:0][31:0] u;
    logic [2:0][29:0] em;
    logic [61:0]      sum;
  } s6_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0]       neg_d;
    logic [2:0][31:0] u;
  } sb3_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][31:0] u;
    logic [2:0][17:0] d;
  } s8_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][31:0] u;
    logic [2:0][17:0] d;
    logic [2:0][49:0] ud;
  } s9_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][31:0] u;
    logic [2:0][17:0] d;
    logic [51:0]      bsum;
  } s10_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][31:0] u;
    logic [2:0][17:0] d;
    logic [34:0]      b;
  } s11_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][31:0] u;
    logic [2:0][17:0] d;
    logic [34:0]      b;
    logic [2:0][52:0] bd;
  } s12_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][31:0] u;
    logic [2:0][17:0] d;
    logic [34:0]      b;
    logic [2:0][36:0] r;
  } s13_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][17:0] d;
    logic [34:0]      b;
    logic [2:0][18:0] p;
  } s14_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][17:0] d;
    logic [34:0]      b;
    logic [2:0][18:0] p;
    logic [2:0][37:0] pp;
  } s15_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][17:0] d;
    logic [34:0]      b;
    logic [2:0][18:0] p;
    logic [39:0]      disc;
  } s16_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][17:0] d;
    logic [34:0]      b;
    logic [2:0][18:0] p;
  } sb4_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][18:0] p;
    logic [2:0][35:0] sd;
  } s17_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][18:0] p;
    logic [2:0][19:0] rsd;
  } s18_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][20:0] q;
  } s19_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][52:0] qs;
  } s20_t;

  typedef struct packed {
    logic             valid;
    logic             bad;
    logic [2:0][36:0] hq;
  } s21_t;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [31:0] center_q [3];
  logic [30:0] semi_q   [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        center_q[i] <= '0;
        semi_q[i]   <= 31'd65536;
      end
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CENTER_X: center_q[0] <= cfg_data_i;
        CFG_CENTER_Y: center_q[1] <= cfg_data_i;
        CFG_CENTER_Z: center_q[2] <= cfg_data_i;
        CFG_SEMI_X:   semi_q[0]   <= cfg_data_i[30:0];
        CFG_SEMI_Y:   semi_q[1]   <= cfg_data_i[30:0];
        CFG_SEMI_Z:   semi_q[2]   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // flow control: everything advances unless a result is held at the output
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic adv;

  assign adv        = !(out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // s0: offset origin by center, split magnitudes and signs
  // --------------------------------------------------------------------------
  logic [31:0] org [3];
  logic [31:0] dir [3];

  assign org[0] = ray_origin_x_i;
  assign org[1] = ray_origin_y_i;
  assign org[2] = ray_origin_z_i;
  assign dir[0] = ray_dir_x_i;
  assign dir[1] = ray_dir_y_i;
  assign dir[2] = ray_dir_z_i;

  s0_t s0_d, s0_q;

  always_comb begin
    logic signed [32:0] o;
    s0_d       = '0;
    s0_d.valid = in_valid_i;
    for (int i = 0; i < 3; i++) begin
      o = $signed({org[i][31], org[i]}) - $signed({center_q[i][31], center_q[i]});
      s0_d.neg_o[i] = o[32];
      s0_d.omag[i]  = o[32] ? 33'(-o) : 33'(o);
      s0_d.neg_d[i] = dir[i][31];
      s0_d.dmag[i]  = dir[i][31] ? 32'(-dir[i]) : dir[i];
      if (semi_q[i] == '0) s0_d.bad = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_q <= '0;
    else if (adv) s0_q <= s0_d;
  end

  // --------------------------------------------------------------------------
  // first divide: u = o/semi, e = |dir|/semi
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0] qu [3];
  logic [DIV_W-1:0] qe [3];

  for (genvar i = 0; i < 3; i++) begin : g_div1
    rei_div u_div_u (
      .clk_i (clk_i),
      .en_i  (adv),
      .dvd_i ({15'd0, s0_q.omag[i], 16'd0}),
      .dvs_i ({1'b0, semi_q[i]}),
      .quo_o (qu[i])
    );
    rei_div u_div_e (
      .clk_i (clk_i),
      .en_i  (adv),
      .dvd_i ({s0_q.dmag[i], 32'd0}),
      .dvs_i ({1'b0, semi_q[i]}),
      .quo_o (qe[i])
    );
  end

  sb1_t dl1_q [DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STEPS; k++) dl1_q[k] <= '0;
    end else if (adv) begin
      dl1_q[0] <= '{valid: s0_q.valid, bad: s0_q.bad, neg_o: s0_q.neg_o, neg_d: s0_q.neg_d};
      for (int k = 1; k < DIV_STEPS; k++) dl1_q[k] <= dl1_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // s1: apply signs, catch far origin, merge e for the leading-one search
  // --------------------------------------------------------------------------
  s1_t s1_d, s1_q;

  always_comb begin
    sb1_t sb;
    sb         = dl1_q[DIV_STEPS-1];
    s1_d       = '0;
    s1_d.valid = sb.valid;
    s1_d.bad   = sb.bad;
    s1_d.neg_d = sb.neg_d;
    for (int i = 0; i < 3; i++) begin
      if (|qu[i][63:31]) s1_d.bad = 1'b1;
      s1_d.u[i] = sb.neg_o[i] ? 32'(-{1'b0, qu[i][30:0]}) : {1'b0, qu[i][30:0]};
      s1_d.e[i] = qe[i];
    end
    s1_d.orv = qe[0] | qe[1] | qe[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_q <= '0;
    else if (adv) s1_q <= s1_d;
  end

  // --------------------------------------------------------------------------
  // s2: leading one within each 16-bit chunk
  // --------------------------------------------------------------------------
  s2_t s2_d, s2_q;

  always_comb begin
    s2_d       = '0;
    s2_d.valid = s1_q.valid;
    s2_d.bad   = s1_q.bad || (s1_q.orv == '0);
    s2_d.neg_d = s1_q.neg_d;
    s2_d.u     = s1_q.u;
    s2_d.e     = s1_q.e;
    for (int c = 0; c < 4; c++) begin
      s2_d.nz[c] = |s1_q.orv[16*c +: 16];
      for (int b = 0; b < 16; b++) begin
        if (s1_q.orv[16*c + b]) s2_d.pos[c] = 4'(b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_q <= '0;
    else if (adv) s2_q <= s2_d;
  end

  // --------------------------------------------------------------------------
  // s3: pick the highest nonzero chunk
  // --------------------------------------------------------------------------
  s3_t s3_d, s3_q;

  always_comb begin
    s3_d       = '0;
    s3_d.valid = s2_q.valid;
    s3_d.bad   = s2_q.bad;
    s3_d.neg_d = s2_q.neg_d;
    s3_d.u     = s2_q.u;
    s3_d.e     = s2_q.e;
    for (int c = 0; c < 4; c++) begin
      if (s2_q.nz[c]) s3_d.lead = {2'(c), s2_q.pos[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_q <= '0;
    else if (adv) s3_q <= s3_d;
  end

  // --------------------------------------------------------------------------
  // s4: shift e as a block so the largest lands in [2^29, 2^30)
  // --------------------------------------------------------------------------
  s4_t s4_d, s4_q;

  always_comb begin
    logic [5:0] rsh;
    logic [5:0] lsh;
    rsh        = 6'(s3_q.lead - 6'd29);
    lsh        = 6'(6'd29 - s3_q.lead);
    s4_d       = '0;
    s4_d.valid = s3_q.valid;
    s4_d.bad   = s3_q.bad;
    s4_d.neg_d = s3_q.neg_d;
    s4_d.u     = s3_q.u;
    for (int i = 0; i < 3; i++) begin
      if (s3_q.lead > 6'd29) s4_d.em[i] = 30'(s3_q.e[i] >> rsh);
      else                   s4_d.em[i] = 30'(s3_q.e[i] << lsh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_q <= '0;
    else if (adv) s4_q <= s4_d;
  end

  // --------------------------------------------------------------------------
  // s5: squares, s6: sum of squares
  // --------------------------------------------------------------------------
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;

  always_comb begin
    s5_d       = '0;
    s5_d.valid = s4_q.valid;
    s5_d.bad   = s4_q.bad;
    s5_d.neg_d = s4_q.neg_d;
    s5_d.u     = s4_q.u;
    s5_d.em    = s4_q.em;
    for (int i = 0; i < 3; i++) s5_d.sq[i] = 60'(s4_q.em[i]) * 60'(s4_q.em[i]);
  end

  always_comb begin
    s6_d       = '0;
    s6_d.valid = s5_q.valid;
    s6_d.bad   = s5_q.bad;
    s6_d.neg_d = s5_q.neg_d;
    s6_d.u     = s5_q.u;
    s6_d.em    = s5_q.em;
    s6_d.sum   = 62'(s5_q.sq[0]) + 62'(s5_q.sq[1]) + 62'(s5_q.sq[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_q <= '0;
      s6_q <= '0;
    end else if (adv) begin
      s5_q <= s5_d;
      s6_q <= s6_d;
    end
  end

  // --------------------------------------------------------------------------
  // vector length
  // --------------------------------------------------------------------------
  logic [ROOT_W-1:0] len;

  rei_sqrt u_sqrt_len (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({2'd0, s6_q.sum}),
    .root_o (len)
  );

  s6_t dl2_q [SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQRT_STEPS; k++) dl2_q[k] <= '0;
    end else if (adv) begin
      dl2_q[0] <= s6_q;
      for (int k = 1; k < SQRT_STEPS; k++) dl2_q[k] <= dl2_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // second divide: d = em/len
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0] qd [3];

  for (genvar i = 0; i < 3; i++) begin : g_div2
    rei_div u_div_d (
      .clk_i (clk_i),
      .en_i  (adv),
      .dvd_i ({18'd0, dl2_q[SQRT_STEPS-1].em[i], 16'd0}),
      .dvs_i (len),
      .quo_o (qd[i])
    );
  end

  sb3_t dl3_q [DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STEPS; k++) dl3_q[k] <= '0;
    end else if (adv) begin
      dl3_q[0] <= '{valid: dl2_q[SQRT_STEPS-1].valid, bad: dl2_q[SQRT_STEPS-1].bad,
                    neg_d: dl2_q[SQRT_STEPS-1].neg_d, u: dl2_q[SQRT_STEPS-1].u};
      for (int k = 1; k < DIV_STEPS; k++) dl3_q[k] <= dl3_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // s8..s11: unit direction, then b = rnd(u.d)
  // --------------------------------------------------------------------------
  s8_t  s8_d,  s8_q;
  s9_t  s9_d,  s9_q;
  s10_t s10_d, s10_q;
  s11_t s11_d, s11_q;

  always_comb begin
    sb3_t sb;
    sb         = dl3_q[DIV_STEPS-1];
    s8_d       = '0;
    s8_d.valid = sb.valid;
    s8_d.bad   = sb.bad;
    s8_d.u     = sb.u;
    for (int i = 0; i < 3; i++) begin
      s8_d.d[i] = sb.neg_d[i] ? 18'(-{1'b0, qd[i][16:0]}) : {1'b0, qd[i][16:0]};
    end
  end

  always_comb begin
    logic signed [49:0] prod;
    s9_d       = '0;
    s9_d.valid = s8_q.valid;
    s9_d.bad   = s8_q.bad;
    s9_d.u     = s8_q.u;
    s9_d.d     = s8_q.d;
    for (int i = 0; i < 3; i++) begin
      prod       = $signed(s8_q.u[i]) * $signed(s8_q.d[i]);
      s9_d.ud[i] = prod;
    end
  end

  always_comb begin
    logic signed [51:0] acc;
    acc = 52'($signed(s9_q.ud[0])) + 52'($signed(s9_q.ud[1]))
        + 52'($signed(s9_q.ud[2]));
    s10_d       = '0;
    s10_d.valid = s9_q.valid;
    s10_d.bad   = s9_q.bad;
    s10_d.u     = s9_q.u;
    s10_d.d     = s9_q.d;
    s10_d.bsum  = acc;
  end

  always_comb begin
    logic signed [63:0] r;
    r           = rnd16(64'($signed(s10_q.bsum)));
    s11_d       = '0;
    s11_d.valid = s10_q.valid;
    s11_d.bad   = s10_q.bad;
    s11_d.u     = s10_q.u;
    s11_d.d     = s10_q.d;
    s11_d.b     = r[34:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_q  <= '0;
      s9_q  <= '0;
      s10_q <= '0;
      s11_q <= '0;
    end else if (adv) begin
      s8_q  <= s8_d;
      s9_q  <= s9_d;
      s10_q <= s10_d;
      s11_q <= s11_d;
    end
  end

  // --------------------------------------------------------------------------
  // s12..s16: nearest point p = u - rnd(b*d), disc = 1 - p.p
  // --------------------------------------------------------------------------
  s12_t s12_d, s12_q;
  s13_t s13_d, s13_q;
  s14_t s14_d, s14_q;
  s15_t s15_d, s15_q;
  s16_t s16_d, s16_q;

  always_comb begin
    logic signed [52:0] prod;
    s12_d       = '0;
    s12_d.valid = s11_q.valid;
    s12_d.bad   = s11_q.bad;
    s12_d.u     = s11_q.u;
    s12_d.d     = s11_q.d;
    s12_d.b     = s11_q.b;
    for (int i = 0; i < 3; i++) begin
      prod        = $signed(s11_q.b) * $signed(s11_q.d[i]);
      s12_d.bd[i] = prod;
    end
  end

  always_comb begin
    logic signed [63:0] r;
    s13_d       = '0;
    s13_d.valid = s12_q.valid;
    s13_d.bad   = s12_q.bad;
    s13_d.u     = s12_q.u;
    s13_d.d     = s12_q.d;
    s13_d.b     = s12_q.b;
    for (int i = 0; i < 3; i++) begin
      r          = rnd16(64'($signed(s12_q.bd[i])));
      s13_d.r[i] = r[36:0];
    end
  end

  always_comb begin
    logic signed [37:0] p;
    s14_d       = '0;
    s14_d.valid = s13_q.valid;
    s14_d.bad   = s13_q.bad;
    s14_d.d     = s13_q.d;
    s14_d.b     = s13_q.b;
    for (int i = 0; i < 3; i++) begin
      p = 38'($signed(s13_q.u[i])) - 38'($signed(s13_q.r[i]));
      // line passes too far off on this axis
      if (p > 38'sd131072 || p < -38'sd131072) s14_d.bad = 1'b1;
      s14_d.p[i] = p[18:0];
    end
  end

  always_comb begin
    logic signed [37:0] sq;
    s15_d       = '0;
    s15_d.valid = s14_q.valid;
    s15_d.bad   = s14_q.bad;
    s15_d.d     = s14_q.d;
    s15_d.b     = s14_q.b;
    s15_d.p     = s14_q.p;
    for (int i = 0; i < 3; i++) begin
      sq          = $signed(s14_q.p[i]) * $signed(s14_q.p[i]);
      s15_d.pp[i] = sq;
    end
  end

  always_comb begin
    logic signed [39:0] dsc;
    dsc = 40'sd4294967296 - 40'($signed(s15_q.pp[0])) - 40'($signed(s15_q.pp[1]))
        - 40'($signed(s15_q.pp[2]));
    s16_d       = '0;
    s16_d.valid = s15_q.valid;
    s16_d.bad   = s15_q.bad || dsc[39];
    s16_d.d     = s15_q.d;
    s16_d.b     = s15_q.b;
    s16_d.p     = s15_q.p;
    s16_d.disc  = dsc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s12_q <= '0;
      s13_q <= '0;
      s14_q <= '0;
      s15_q <= '0;
      s16_q <= '0;
    end else if (adv) begin
      s12_q <= s12_d;
      s13_q <= s13_d;
      s14_q <= s14_d;
      s15_q <= s15_d;
      s16_q <= s16_d;
    end
  end

  // --------------------------------------------------------------------------
  // s = sqrt(disc)
  // --------------------------------------------------------------------------
  logic [ROOT_W-1:0] sroot;

  rei_sqrt u_sqrt_disc (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (s16_q.disc[39] ? '0 : {24'd0, s16_q.disc}),
    .root_o (sroot)
  );

  sb4_t dl4_q [SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQRT_STEPS; k++) dl4_q[k] <= '0;
    end else if (adv) begin
      dl4_q[0] <= '{valid: s16_q.valid, bad: s16_q.bad, d: s16_q.d, b: s16_q.b, p: s16_q.p};
      for (int k = 1; k < SQRT_STEPS; k++) dl4_q[k] <= dl4_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // s17..s21: root test, hit point, scale back by semi-axes
  // --------------------------------------------------------------------------
  s17_t s17_d, s17_q;
  s18_t s18_d, s18_q;
  s19_t s19_d, s19_q;
  s20_t s20_d, s20_q;
  s21_t s21_d, s21_q;

  always_comb begin
    sb4_t               sb;
    logic signed [17:0] s_s;
    logic signed [35:0] prod;
    sb          = dl4_q[SQRT_STEPS-1];
    s_s         = $signed({1'b0, sroot[16:0]});
    s17_d       = '0;
    s17_d.valid = sb.valid;
    // nearer root negative: origin inside or past the ellipsoid
    s17_d.bad   = sb.bad || ($signed(sb.b) > -36'(s_s));
    s17_d.p     = sb.p;
    for (int i = 0; i < 3; i++) begin
      prod        = s_s * $signed(sb.d[i]);
      s17_d.sd[i] = prod;
    end
  end

  always_comb begin
    logic signed [63:0] r;
    s18_d       = '0;
    s18_d.valid = s17_q.valid;
    s18_d.bad   = s17_q.bad;
    s18_d.p     = s17_q.p;
    for (int i = 0; i < 3; i++) begin
      r            = rnd16(64'($signed(s17_q.sd[i])));
      s18_d.rsd[i] = r[19:0];
    end
  end

  always_comb begin
    s19_d       = '0;
    s19_d.valid = s18_q.valid;
    s19_d.bad   = s18_q.bad;
    for (int i = 0; i < 3; i++) begin
      s19_d.q[i] = 21'($signed(s18_q.p[i])) - 21'($signed(s18_q.rsd[i]));
    end
  end

  always_comb begin
    logic signed [52:0] prod;
    s20_d       = '0;
    s20_d.valid = s19_q.valid;
    s20_d.bad   = s19_q.bad;
    for (int i = 0; i < 3; i++) begin
      prod        = $signed(s19_q.q[i]) * $signed({1'b0, semi_q[i]});
      s20_d.qs[i] = prod;
    end
  end

  always_comb begin
    logic signed [63:0] r;
    s21_d       = '0;
    s21_d.valid = s20_q.valid;
    s21_d.bad   = s20_q.bad;
    for (int i = 0; i < 3; i++) begin
      r           = rnd16(64'($signed(s20_q.qs[i])));
      s21_d.hq[i] = r[36:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s17_q <= '0;
      s18_q <= '0;
      s19_q <= '0;
      s20_q <= '0;
      s21_q <= '0;
    end else if (adv) begin
      s17_q <= s17_d;
      s18_q <= s18_d;
      s19_q <= s19_d;
      s20_q <= s20_d;
      s21_q <= s21_d;
    end
  end

  // --------------------------------------------------------------------------
  // output register: add center, clear hit and coordinates for out-of-range results
  // --------------------------------------------------------------------------
  logic        hit_d, hit_q;
  logic [31:0] hc_d [3];
  logic [31:0] hc_q [3];

  always_comb begin
    logic signed [37:0] h [3];
    logic               ovf;
    ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      h[i] = 38'($signed(s21_q.hq[i])) + 38'($signed(center_q[i]));
      if (h[i][37:31] != {7{h[i][31]}}) ovf = 1'b1;
    end
    hit_d = !s21_q.bad && !ovf;
    for (int i = 0; i < 3; i++) hc_d[i] = hit_d ? h[i][31:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      for (int i = 0; i < 3; i++) hc_q[i] <= '0;
    end else if (adv) begin
      out_valid_q <= s21_q.valid;
      hit_q       <= hit_d;
      for (int i = 0; i < 3; i++) hc_q[i] <= hc_d[i];
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;
  assign hit_x_o     = hc_q[0];
  assign hit_y_o     = hc_q[1];
  assign hit_z_o     = hc_q[2];

endmodule
